// File: sv/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  // Default geometry
  localparam int ROW_COUNT_DEF    = 25;
  localparam int COLUMN_COUNT_DEF = 80;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int POS_W  = 11;

  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0f;

  // Command codes on the input stream
  localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SETCUR = 2'd3;

  localparam int QUEUE_DEPTH = 2;

  // Classified operation handed from the front to the back
  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_CLEAR,
    OP_READ,
    OP_READ_MISS,
    OP_SETCUR
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  pos;        // read index or saturated cursor
  } cmd_t;

  typedef struct packed {
    logic              scrolled;
    logic [ATTR_W-1:0] cell_attr;
    logic [CHAR_W-1:0] cell_char;
    logic [POS_W-1:0]  cursor;
  } result_t;

endpackage

`default_nettype wire

// File: sv/tcw_front.sv
`default_nettype none

module tcw_front #(
  parameter int CELL_COUNT = tcw_pkg::ROW_COUNT_DEF * tcw_pkg::COLUMN_COUNT_DEF
) (
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [31:0]              s_tdata,
  input  wire logic [tcw_pkg::CMD_W-1:0] s_tuser,
  input  wire logic                     init_busy,
  input  wire logic                     q_full,
  output logic                          push,
  output tcw_pkg::cmd_t                 push_cmd
);

  localparam logic [31:0] CELL_LIM  = 32'(CELL_COUNT);
  localparam logic [31:0] LAST_CELL = 32'(CELL_COUNT - 1);

  logic [tcw_pkg::CHAR_W-1:0] char_code;
  logic [tcw_pkg::POS_W-1:0]  cell_index;
  logic [tcw_pkg::POS_W-1:0]  new_cursor;
  logic                       in_range;
  logic [tcw_pkg::POS_W-1:0]  sat_cursor;

  assign char_code  = s_tdata[7:0];
  assign cell_index = s_tdata[18:8];
  assign new_cursor = s_tdata[29:19];

  assign in_range   = 32'(cell_index) < CELL_LIM;
  assign sat_cursor = (32'(new_cursor) > LAST_CELL) ? tcw_pkg::POS_W'(LAST_CELL) : new_cursor;

  // Hold off input during the power-up sweep or when the queue is full
  assign s_tready = !init_busy && !q_full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    push_cmd.char_code = char_code;
    push_cmd.pos       = cell_index;
    push_cmd.op        = tcw_pkg::OP_PUT;
    unique case (s_tuser)
      tcw_pkg::CMD_PUT: begin
        push_cmd.op = (char_code == tcw_pkg::NEWLINE_CODE) ? tcw_pkg::OP_NEWLINE
                                                          : tcw_pkg::OP_PUT;
      end
      tcw_pkg::CMD_CLEAR: begin
        push_cmd.op = tcw_pkg::OP_CLEAR;
      end
      tcw_pkg::CMD_READ: begin
        push_cmd.op = in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_READ_MISS;
      end
      tcw_pkg::CMD_SETCUR: begin
        push_cmd.op  = tcw_pkg::OP_SETCUR;
        push_cmd.pos = sat_cursor;
      end
      default: begin
        push_cmd.op = tcw_pkg::OP_PUT;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/tcw_queue.sv
`default_nettype none

module tcw_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  tcw_pkg::cmd_t      push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output tcw_pkg::cmd_t      pop_data
);

  localparam int DEPTH = tcw_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  tcw_pkg::cmd_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(DEPTH);
  assign valid    = count != '0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/tcw_back.sv
`default_nettype none

module tcw_back #(
  parameter int ROW_COUNT    = tcw_pkg::ROW_COUNT_DEF,
  parameter int COLUMN_COUNT = tcw_pkg::COLUMN_COUNT_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [tcw_pkg::ATTR_W-1:0] text_attribute,
  input  wire logic                      q_valid,
  input  tcw_pkg::cmd_t                  q_cmd,
  output logic                           q_pop,
  output logic                           init_busy,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output tcw_pkg::result_t               m_result
);

  localparam int CELL_COUNT = ROW_COUNT * COLUMN_COUNT;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int SUM_W      = ADDR_W + 1;
  localparam int FILL_W     = $clog2(COLUMN_COUNT);
  localparam int POS_W      = tcw_pkg::POS_W;
  localparam int CHAR_W     = tcw_pkg::CHAR_W;
  localparam int ATTR_W     = tcw_pkg::ATTR_W;

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW  = ADDR_W'(CELL_COUNT - COLUMN_COUNT);
  localparam logic [ADDR_W-1:0] COL_STEP  = ADDR_W'(COLUMN_COUNT);
  localparam logic [SUM_W-1:0]  COLS_S    = SUM_W'(COLUMN_COUNT);
  localparam logic [SUM_W-1:0]  CELLS_S   = SUM_W'(CELL_COUNT);
  localparam logic [FILL_W-1:0] LAST_COL  = FILL_W'(COLUMN_COUNT - 1);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FILL  = 3'd2;
  localparam logic [2:0] ST_CLEAR = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_SEEK  = 3'd5;

  logic [CHAR_W-1:0] char_mem [CELL_COUNT];
  logic [ATTR_W-1:0] attr_mem [CELL_COUNT];

  logic [2:0]        state;
  logic [ADDR_W-1:0] cursor;
  logic [ADDR_W-1:0] row_start;
  logic [ADDR_W-1:0] base;       // physical address of the top screen row
  logic [ADDR_W-1:0] sweep;
  logic [FILL_W-1:0] fill_cnt;
  logic              out_valid;
  tcw_pkg::result_t  out_result;

  logic              start;
  logic              we_char;
  logic              we_attr;
  logic [ADDR_W-1:0] waddr;
  logic [CHAR_W-1:0] wchar;
  logic [ATTR_W-1:0] wattr;
  logic [ADDR_W-1:0] raddr;
  logic [CHAR_W-1:0] rd_char;
  logic [ATTR_W-1:0] rd_attr;
  logic              put_wraps_row;
  logic              seek_step;

  // Map a screen position onto the ring of rows
  function automatic logic [ADDR_W-1:0] to_phys(input logic [ADDR_W-1:0] lin,
                                                input logic [ADDR_W-1:0] top);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, lin} + {1'b0, top};
    if (sum >= CELLS_S) begin
      sum = sum - CELLS_S;
    end
    return sum[ADDR_W-1:0];
  endfunction

  function automatic tcw_pkg::result_t make_result(input logic [ADDR_W-1:0] cur,
                                                   input logic [CHAR_W-1:0] ch,
                                                   input logic [ATTR_W-1:0] at,
                                                   input logic              sc);
    tcw_pkg::result_t r;
    r.cursor    = POS_W'(cur);
    r.cell_char = ch;
    r.cell_attr = at;
    r.scrolled  = sc;
    return r;
  endfunction

  assign init_busy = state == ST_INIT;
  assign start     = (state == ST_IDLE) && q_valid && !out_valid;
  assign q_pop     = start;
  assign m_tvalid  = out_valid;
  assign m_result  = out_result;
  assign raddr     = to_phys(ADDR_W'(q_cmd.pos), base);

  assign put_wraps_row = ({1'b0, cursor} + SUM_W'(1)) == ({1'b0, row_start} + COLS_S);
  assign seek_step     = ({1'b0, row_start} + COLS_S) <= {1'b0, cursor};

  // Write port steering
  always_comb begin
    we_char = 1'b0;
    we_attr = 1'b0;
    waddr   = sweep;
    wchar   = tcw_pkg::SPACE_CODE;
    wattr   = tcw_pkg::RESET_ATTR;
    unique case (state)
      ST_INIT: begin
        we_char = 1'b1;
        we_attr = 1'b1;
      end
      ST_CLEAR: begin
        we_char = 1'b1;
      end
      ST_FILL: begin
        we_char = 1'b1;
        we_attr = 1'b1;
        waddr   = base + ADDR_W'(fill_cnt);
        wattr   = text_attribute;
      end
      ST_IDLE: begin
        if (start && q_cmd.op == tcw_pkg::OP_PUT) begin
          we_char = 1'b1;
          we_attr = 1'b1;
          waddr   = to_phys(cursor, base);
          wchar   = q_cmd.char_code;
          wattr   = text_attribute;
        end
      end
      default: begin
        we_char = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_char) begin
      char_mem[waddr] <= wchar;
    end
    if (we_attr) begin
      attr_mem[waddr] <= wattr;
    end
    rd_char <= char_mem[raddr];
    rd_attr <= attr_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      cursor    <= '0;
      row_start <= '0;
      base      <= '0;
      sweep     <= '0;
      fill_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_INIT: begin
          sweep <= sweep + 1'b1;
          if (sweep == LAST_CELL) begin
            sweep <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            unique case (q_cmd.op)
              tcw_pkg::OP_PUT: begin
                if (cursor == LAST_CELL) begin
                  cursor   <= LAST_ROW;
                  fill_cnt <= '0;
                  state    <= ST_FILL;
                end else begin
                  cursor <= cursor + 1'b1;
                  if (put_wraps_row) begin
                    row_start <= cursor + 1'b1;
                  end
                  out_valid  <= 1'b1;
                  out_result <= make_result(cursor + 1'b1, '0, '0, 1'b0);
                end
              end
              tcw_pkg::OP_NEWLINE: begin
                if (row_start == LAST_ROW) begin
                  cursor   <= LAST_ROW;
                  fill_cnt <= '0;
                  state    <= ST_FILL;
                end else begin
                  cursor     <= row_start + COL_STEP;
                  row_start  <= row_start + COL_STEP;
                  out_valid  <= 1'b1;
                  out_result <= make_result(row_start + COL_STEP, '0, '0, 1'b0);
                end
              end
              tcw_pkg::OP_CLEAR: begin
                cursor    <= '0;
                row_start <= '0;
                sweep     <= '0;
                state     <= ST_CLEAR;
              end
              tcw_pkg::OP_READ: begin
                state <= ST_READ;
              end
              tcw_pkg::OP_READ_MISS: begin
                out_valid  <= 1'b1;
                out_result <= make_result(cursor, '0, '0, 1'b0);
              end
              tcw_pkg::OP_SETCUR: begin
                cursor    <= ADDR_W'(q_cmd.pos);
                row_start <= '0;
                state     <= ST_SEEK;
              end
              default: begin
                out_valid  <= 1'b1;
                out_result <= make_result(cursor, '0, '0, 1'b0);
              end
            endcase
          end
        end
        ST_FILL: begin
          fill_cnt <= fill_cnt + 1'b1;
          if (fill_cnt == LAST_COL) begin
            base       <= (base == LAST_ROW) ? '0 : base + COL_STEP;
            out_valid  <= 1'b1;
            out_result <= make_result(cursor, '0, '0, 1'b1);
            state      <= ST_IDLE;
          end
        end
        ST_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == LAST_CELL) begin
            sweep      <= '0;
            out_valid  <= 1'b1;
            out_result <= make_result(cursor, '0, '0, 1'b0);
            state      <= ST_IDLE;
          end
        end
        ST_READ: begin
          out_valid  <= 1'b1;
          out_result <= make_result(cursor, rd_char, rd_attr, 1'b0);
          state      <= ST_IDLE;
        end
        ST_SEEK: begin
          if (seek_step) begin
            row_start <= row_start + COL_STEP;
          end else begin
            out_valid  <= 1'b1;
            out_result <= make_result(cursor, '0, '0, 1'b0);
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/text_console_writer_core.sv
// Channel   Dir  Handshake            Word layout (low bit up)
// s_*       in   s_tvalid / s_tready  tdata: char_code[7:0] cell_index[18:8]
//                                     new_cursor[29:19]; tuser: cmd[1:0]
// m_*       out  m_tvalid / m_tready  tdata: cursor[10:0] cell_char[18:11]
//                                     cell_attr[26:19] scrolled[27]
// apb       in   psel/penable/pwrite  reg 0 at 0x0: text_attribute[7:0]
//
// Per word: a plain character or newline that scrolls the screen also
// fills the bottom row (one bottom-row cell filled per cycle); a set
// cursor runs a row search (row search steps one row a cycle); a clear
// writes space through the character memory (one cell per cycle).
// Back end starts a word only when the result register is free.
// Reset: synchronous, active high. After reset a sweep writes space on
// 0x0f to every cell while s_tready stays low; config writes are taken
// throughout.
// Stalls: a two-word queue lets the input side run ahead of the back end;
// a stalled result holds in the output register.
`default_nettype none

module text_console_writer_core #(
  parameter int ROW_COUNT    = tcw_pkg::ROW_COUNT_DEF,
  parameter int COLUMN_COUNT = tcw_pkg::COLUMN_COUNT_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [31:0]               s_tdata,   // char_code, cell_index, new_cursor
  input  wire logic [tcw_pkg::CMD_W-1:0] s_tuser,   // cmd
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [31:0]                    m_tdata,   // cursor, cell_char, cell_attr, scrolled
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int CELL_COUNT = ROW_COUNT * COLUMN_COUNT;
  localparam int RES_W      = $bits(tcw_pkg::result_t);

  logic [tcw_pkg::ATTR_W-1:0] text_attribute;
  logic                       init_busy;
  logic                       q_full;
  logic                       q_valid;
  logic                       push;
  logic                       pop;
  tcw_pkg::cmd_t              push_cmd;
  tcw_pkg::cmd_t              q_cmd;
  tcw_pkg::result_t           result;

  // Config register: only the attribute byte; upper address bit selects
  // beyond the register list
  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : 32'(text_attribute);

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= tcw_pkg::RESET_ATTR;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      text_attribute <= pwdata[tcw_pkg::ATTR_W-1:0];
    end
  end

  // Front: accept and classify
  tcw_front #(
    .CELL_COUNT (CELL_COUNT)
  ) u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .init_busy (init_busy),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Decouple front from back
  tcw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .pop_data  (q_cmd)
  );

  // Back: cell store, cursor, scroll and clear sequencer
  tcw_back #(
    .ROW_COUNT    (ROW_COUNT),
    .COLUMN_COUNT (COLUMN_COUNT)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .text_attribute (text_attribute),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (pop),
    .init_busy      (init_busy),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_result       (result)
  );

  // Pad the result word to 32 bits
  assign m_tdata = {{(32 - RES_W){1'b0}}, result};

endmodule

`default_nettype wire

// File: sv/tcw_checker.sv
`default_nettype none

module tcw_checker #(
  parameter int ROW_COUNT    = tcw_pkg::ROW_COUNT_DEF,
  parameter int COLUMN_COUNT = tcw_pkg::COLUMN_COUNT_DEF
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  localparam int          CELL_COUNT = ROW_COUNT * COLUMN_COUNT;
  localparam bit          WIDE       = CELL_COUNT >= 2048;
  localparam logic [10:0] CELL_LIM   = 11'(CELL_COUNT);
  localparam logic [10:0] BOTTOM_ROW = 11'(CELL_COUNT - COLUMN_COUNT);

  // Power-up sweep blocks input right after reset
  a_sweep_blocks_input: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input accepted during cell store sweep");

  a_reset_drops_result: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> WIDE || (m_tdata[10:0] < CELL_LIM))
    else $error("cursor beyond last cell");

  // After a scroll the cursor sits at the start of the bottom row
  a_scroll_bottom_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[27] |-> m_tdata[10:0] == BOTTOM_ROW)
    else $error("scroll left cursor off the bottom row start");

endmodule

bind text_console_writer_core tcw_checker #(
  .ROW_COUNT    (ROW_COUNT),
  .COLUMN_COUNT (COLUMN_COUNT)
) u_tcw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
